FILE: rtl/circular_queue_with_search_core_macros.svh
// Assertion macros used by the checker file.
// Both sample on the rising edge of clk.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_CORE_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_CORE_MACROS_SVH

// Checked only out of reset.
`define CQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cqs_pkg.sv
package cqs_pkg;

  // Fixed field widths
  localparam int ITEM_W = 32;
  localparam int ACT_W  = 3;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_DEPTH  = 16;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int CAP_RESET      = 16;
  localparam int CAP_FLOOR      = 2;

  // Stream packing
  localparam int IN_FIELDS_W  = ACT_W + ITEM_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ITEM_W + 1 + STAT_W + 1 + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Result bit positions in out_tdata
  localparam int O_FOUND_BIT = ITEM_W;
  localparam int O_STAT_LSB  = ITEM_W + 1;
  localparam int O_EMPTY_BIT = O_STAT_LSB + STAT_W;
  localparam int O_FULL_BIT  = O_EMPTY_BIT + 1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEQUEUE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic              found;
    logic [STAT_W-1:0] status;
    logic              is_empty;
    logic              is_full;
  } cqs_flags_t;

endpackage

FILE: rtl/cqs_seq.sv
module cqs_seq import cqs_pkg::*; #(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CAP_W-1:0]  cap_i,
  input  logic              cfg_clr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ACT_W-1:0]  in_action_i,
  input  logic [ITEM_W-1:0] in_item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [ITEM_W-1:0] res_value_o,
  output cqs_flags_t        res_flags_o
);

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CMP_W = ((IDX_W + 1) > CAP_W) ? (IDX_W + 1) : CAP_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_OP     = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } cqs_state_t;

  // Ring increment, wraps at the capacity in use
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] n;
    n = CMP_W'(idx) + CMP_W'(1);
    return (n >= CMP_W'(cap)) ? '0 : IDX_W'(n);
  endfunction

  cqs_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [ACT_W-1:0]      action_r, action_nxt;
  logic [DATA_WIDTH-1:0] item_r, item_nxt;
  logic [ITEM_W-1:0]     rd_value_r, rd_value_nxt;
  logic                  found_r, found_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;

  logic [DATA_WIDTH-1:0] entry_store_r [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      rd_addr;

  // Shared pointer incrementer
  logic [IDX_W-1:0]      inc_in;
  logic [IDX_W-1:0]      inc_out;

  logic                  empty_w;
  logic                  full_w;

  assign inc_out = ring_next(inc_in, cap_i);
  assign empty_w = (head_r == tail_r);
  assign full_w  = (ring_next(tail_r, cap_i) == head_r);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    ptr_nxt      = ptr_r;
    action_nxt   = action_r;
    item_nxt     = item_r;
    rd_value_nxt = rd_value_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    rd_addr      = head_r;
    inc_in       = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          action_nxt   = in_action_i;
          item_nxt     = DATA_WIDTH'(in_item_i);
          rd_value_nxt = '0;
          found_nxt    = 1'b0;
          status_nxt   = STAT_OK;
          state_nxt    = S_OP;
        end
      end
      S_OP: begin
        state_nxt = S_DONE;
        case (action_r)
          ACT_ENQUEUE: begin
            inc_in = tail_r;
            if (full_w) begin
              status_nxt = STAT_FULL;
            end else begin
              mem_we   = 1'b1;
              tail_nxt = inc_out;
            end
          end
          ACT_DEQUEUE, ACT_PEEK: begin
            if (empty_w) begin
              status_nxt = STAT_EMPTY;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_RDWAIT;
            end
          end
          ACT_CLEAR: begin
            head_nxt = '0;
            tail_nxt = '0;
          end
          ACT_SEARCH: begin
            if (!empty_w) begin
              mem_re    = 1'b1;
              ptr_nxt   = head_r;
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        inc_in       = head_r;
        rd_value_nxt = ITEM_W'(rdata_r);
        if (action_r == ACT_DEQUEUE) begin
          head_nxt = inc_out;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // rdata_r holds the entry at ptr_r
        inc_in = ptr_r;
        if (rdata_r == item_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (inc_out == tail_r) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = inc_out;
          mem_re  = 1'b1;
          rd_addr = inc_out;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_clr_i) begin
      head_nxt = '0;
      tail_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    action_r   <= action_nxt;
    item_r     <= item_nxt;
    rd_value_r <= rd_value_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_store_r[tail_r] <= item_r;
    end
    if (mem_re) begin
      rdata_r <= entry_store_r[rd_addr];
    end
  end

  assign in_ready_o           = (state_r == S_IDLE);
  assign res_valid_o          = (state_r == S_DONE);
  assign res_value_o          = rd_value_r;
  assign res_flags_o.found    = found_r;
  assign res_flags_o.status   = status_r;
  assign res_flags_o.is_empty = empty_w;
  assign res_flags_o.is_full  = full_w;

endmodule

FILE: rtl/circular_queue_with_search_core.sv
// Requests are taken one at a time: in_tready is high only while the sequencer is idle, and a
//   new request is accepted once the previous result has moved into the output register.
// A search walks the ring one entry per cycle through the entry memory and one shared
//   comparator, from head up to tail or the first match.
// Reset (rst_n low, synchronous): queue empty, capacity = min(16, MAX_DEPTH),
//   no result pending. Entry contents are not cleared; no clearing pass.
module circular_queue_with_search_core import cqs_pkg::*; #(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // action[2:0], item_value[34:3], zero pad
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // read_value[31:0], found[32], status[34:33],
                                             // is_empty[35], is_full[36], zero pad
  // Capacity register
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data
);

  // Largest capacity the 5-bit register can hold, clipped to the ring size
  localparam int CAP_TOP    = (1 << CAP_W) - 1;
  localparam int CAP_HI_INT = (MAX_DEPTH > CAP_TOP) ? CAP_TOP : MAX_DEPTH;
  localparam int CAP_RS_INT = (CAP_RESET > CAP_HI_INT) ? CAP_HI_INT : CAP_RESET;
  localparam logic [CAP_W-1:0] CAP_HI  = CAP_W'(CAP_HI_INT);
  localparam logic [CAP_W-1:0] CAP_LO  = CAP_W'(CAP_FLOOR);
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(CAP_RS_INT);

  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                   res_valid;
  logic                   res_ready;
  logic [ITEM_W-1:0]      res_value;
  cqs_flags_t             res_flags;
  logic                   res_load;

  // Capacity write: saturate into [2, min(MAX_DEPTH, 31)]; the sequencer empties the
  // queue on the same edge.
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < CAP_LO) begin
        cap_nxt = CAP_LO;
      end else if (cfg_wr_data > CAP_HI) begin
        cap_nxt = CAP_HI;
      end else begin
        cap_nxt = cfg_wr_data;
      end
    end
  end

  cqs_seq #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cap_i       (cap_r),
    .cfg_clr_i   (cfg_wr_en),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .in_action_i (in_tdata[ACT_W-1:0]),
    .in_item_i   (in_tdata[ACT_W +: ITEM_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_value_o (res_value),
    .res_flags_o (res_flags)
  );

  // Output register: a finished result waits here so the sequencer can take
  // the next request.
  assign res_ready = !out_tvalid_r || out_tready;
  assign res_load  = res_valid && res_ready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      cap_r        <= cap_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, res_flags.is_full, res_flags.is_empty,
                      res_flags.status, res_flags.found, res_value};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: rtl/cqs_checker.sv
`include "circular_queue_with_search_core_macros.svh"

module cqs_checker import cqs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [STAT_W-1:0] stat_w;
  assign stat_w = out_tdata[O_STAT_LSB +: STAT_W];

  // Stalled result holds
  `CQS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  // Capacity >= 2, so the queue is never both empty and full
  `CQS_ASSERT(a_empty_full, out_tvalid |-> !(out_tdata[O_EMPTY_BIT] && out_tdata[O_FULL_BIT]), "empty and full together")
  // A dropped enqueue leaves the queue full
  `CQS_ASSERT(a_drop_full, out_tvalid && (stat_w == STAT_FULL) |-> out_tdata[O_FULL_BIT], "drop without full")
  // A read on empty leaves the queue empty
  `CQS_ASSERT(a_read_empty, out_tvalid && (stat_w == STAT_EMPTY) |-> out_tdata[O_EMPTY_BIT], "empty read on nonempty queue")
  // Reset drops any pending result
  `CQS_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind circular_queue_with_search_core cqs_checker u_cqs_checker (.*);

FILE: sim/circular_queue_with_search_core_tb.sv
`timescale 1ns / 1ps

module circular_queue_with_search_core_tb;
  import cqs_pkg::*;

  // Action codes the block treats as no-ops
  localparam logic [ACT_W-1:0] ACT_NOP_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_NOP_LAST  = 3'd7;

  localparam int LONG_STALL = 400;  // receiver hold-off, cycles
  localparam int DRAIN_TAIL = 40;   // settling margin after the bench goes idle

  // One request as it travels on in_tdata
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ITEM_W-1:0] value;
  } cq_req_t;

  // One result as it travels on out_tdata
  typedef struct packed {
    logic [ITEM_W-1:0] read_value;
    logic              found;
    logic [STAT_W-1:0] status;
    logic              is_empty;
    logic              is_full;
  } cq_result_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;

  circular_queue_with_search_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue model: ring storage, head/tail, ring size in use.
  // ---------------------------------------------------------------------------
  logic [ITEM_W-1:0] slot_mem [DEF_MAX_DEPTH];
  int unsigned       q_head    = 0;
  int unsigned       q_tail    = 0;
  int unsigned       ring_size = CAP_RESET;

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= ring_size) ? 0 : idx + 1;
  endfunction

  // Capacity write saturates into [CAP_FLOOR, DEF_MAX_DEPTH] and empties the ring.
  function automatic void set_ring_size(logic [CAP_W-1:0] v);
    int unsigned n;
    n = v;
    if (n < CAP_FLOOR) n = CAP_FLOOR;
    if (n > DEF_MAX_DEPTH) n = DEF_MAX_DEPTH;
    ring_size = n;
    q_head    = 0;
    q_tail    = 0;
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic cq_result_t queue_step(cq_req_t r);
    cq_result_t  res;
    int unsigned idx;
    res = '0;
    case (r.action)
      ACT_ENQUEUE: begin
        if (ring_next(q_tail) == q_head) begin
          res.status = STAT_FULL;     // dropped, state untouched
        end else begin
          slot_mem[q_tail] = r.value;
          q_tail = ring_next(q_tail);
        end
      end
      ACT_DEQUEUE: begin
        if (q_head == q_tail) begin
          res.status = STAT_EMPTY;
        end else begin
          res.read_value = slot_mem[q_head];
          q_head = ring_next(q_head);
        end
      end
      ACT_PEEK: begin
        if (q_head == q_tail) res.status = STAT_EMPTY;
        else res.read_value = slot_mem[q_head];
      end
      ACT_CLEAR: begin
        q_head = 0;
        q_tail = 0;
      end
      ACT_SEARCH: begin
        // walk head up to (not including) tail
        idx = q_head;
        for (int g = 0; g < DEF_MAX_DEPTH && idx != q_tail && !res.found; g++) begin
          if (slot_mem[idx] == r.value) res.found = 1'b1;
          idx = ring_next(idx);
        end
      end
      default: ;  // unused codes: nothing happens
    endcase
    res.is_empty = (q_head == q_tail);
    res.is_full  = (ring_next(q_tail) == q_head);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  cq_req_t    pending_ops[$];   // requests not yet offered
  cq_result_t due_results[$];   // results owed by the block, oldest first
  int         idle_pct   = 0;   // odds (%) of an idle burst after each request sent or ready cycle
  int         stall_asks = 0;   // bumped to request a long receiver hold-off
  int         mismatches = 0;

  // ---------------------------------------------------------------------------
  // Request driver. A request counts as taken at the edge where tvalid and
  // tready are both high; its result is predicted right then, so model state
  // follows the block's acceptance order.
  // ---------------------------------------------------------------------------
  cq_req_t offered;
  int      send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) due_results.push_back(queue_step(offered));
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        offered   = pending_ops.pop_front();
        in_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, offered.value, offered.action};
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side ready: random stall bursts plus the occasional long hold-off,
  // counted here so the sender keeps pushing while the block backs up.
  // ---------------------------------------------------------------------------
  int stall_seen = 0;
  int stall_left = 0;
  int rx_gap     = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_seen != stall_asks) begin
        stall_seen = stall_asks;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) rx_gap = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every taken result against the oldest prediction.
  // ---------------------------------------------------------------------------
  cq_result_t got;
  cq_result_t want;

  task automatic check_field(string name, logic [ITEM_W-1:0] exp_v, logic [ITEM_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.read_value = out_tdata[ITEM_W-1:0];
      got.found      = out_tdata[O_FOUND_BIT];
      got.status     = out_tdata[O_STAT_LSB +: STAT_W];
      got.is_empty   = out_tdata[O_EMPTY_BIT];
      got.is_full    = out_tdata[O_FULL_BIT];
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: read_value %0h", got.read_value);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("read_value", want.read_value, got.read_value);
        check_field("found",      want.found,      got.found);
        check_field("status",     want.status,     got.status);
        check_field("is_empty",   want.is_empty,   got.is_empty);
        check_field("is_full",    want.is_full,    got.is_full);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [ITEM_W-1:0] value_pool [8];   // small per-phase set so searches hit

  task automatic push_req(logic [ACT_W-1:0] a, logic [ITEM_W-1:0] v);
    cq_req_t r;
    r.action = a;
    r.value  = v;
    pending_ops.push_back(r);
  endtask

  // Block is idle: nothing queued, nothing offered, nothing owed.
  // Checked at the falling edge to stay clear of the driver's updates.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || due_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    set_ring_size(v);
  endtask

  function automatic logic [ITEM_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [ACT_W-1:0] ACT_LAST_NOP();
    return ACT_W'($urandom_range(ACT_NOP_FIRST, ACT_NOP_LAST));
  endfunction

  // enq_pct steers fill level: high values push the ring toward full.
  task automatic push_random(int enq_pct);
    int r;
    if ($urandom_range(0, 99) < enq_pct) begin
      push_req(ACT_ENQUEUE, pick_value());
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45)      push_req(ACT_DEQUEUE, $urandom);
      else if (r < 60) push_req(ACT_PEEK, $urandom);
      else if (r < 90) push_req(ACT_SEARCH, pick_value());
      else if (r < 93) push_req(ACT_CLEAR, $urandom);
      else             push_req(ACT_LAST_NOP(), $urandom);
    end
  endtask

  task automatic random_phase(logic [CAP_W-1:0] cap, int enq_pct, int gaps, int n,
                              bit long_stall);
    write_capacity(cap);
    idle_pct = gaps;
    foreach (value_pool[i])
      value_pool[i] = ($urandom_range(0, 3) == 0) ? ITEM_W'($urandom_range(0, 15)) : $urandom;
    for (int k = 0; k < n; k++) begin
      push_random(enq_pct);
      // halfway through: hold results off while requests keep coming
      if (long_stall && k == n / 2) begin
        @(negedge clk);
        stall_asks++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset capacity (15 usable): empty reads, extremes, no-op codes
    idle_pct = 20;
    push_req(ACT_DEQUEUE, '0);
    push_req(ACT_PEEK, '1);
    push_req(ACT_SEARCH, '0);            // search on an empty ring
    push_req(ACT_ENQUEUE, '0);
    push_req(ACT_ENQUEUE, '1);
    push_req(ACT_PEEK, '0);
    push_req(ACT_SEARCH, '1);            // hit on second entry
    push_req(ACT_SEARCH, 32'h0000_0001); // miss
    push_req(ACT_NOP_FIRST, '1);
    push_req(ACT_NOP_FIRST + 3'd1, '1);
    push_req(ACT_NOP_LAST, '1);
    push_req(ACT_DEQUEUE, '1);
    push_req(ACT_DEQUEUE, '1);
    push_req(ACT_DEQUEUE, '1);           // read past the last entry
    push_req(ACT_CLEAR, '1);

    // Directed, smallest ring (one usable slot): full drop, clear while full
    write_capacity(5'd2);
    push_req(ACT_ENQUEUE, 32'hA5A5_A5A5);
    push_req(ACT_ENQUEUE, 32'h5A5A_5A5A);  // dropped, full
    push_req(ACT_SEARCH, 32'hA5A5_A5A5);
    push_req(ACT_PEEK, '0);
    push_req(ACT_CLEAR, '0);
    push_req(ACT_PEEK, '0);
    push_req(ACT_ENQUEUE, 32'h0000_0001);
    push_req(ACT_DEQUEUE, '0);

    // Random phases; out-of-range writes saturate to the nearest legal size
    random_phase(5'd0,  50, 20, 200, 1'b0);
    random_phase(5'd31, 62, 20, 250, 1'b1);
    random_phase(5'd5,  50, 0,  300, 1'b0);
    random_phase(5'd1,  45, 30, 275, 1'b0);
    random_phase(5'd17, 60, 15, 250, 1'b0);
    random_phase(CAP_W'($urandom_range(0, 31)), 52, 25, 250, 1'b0);
    // closing stretch runs with no idling on either side
    random_phase(5'd16, 55, 0,  250, 1'b0);

    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
